[rtl/kvt_pkg.sv]
`timescale 1ns / 1ps

package kvt_pkg;

	// request codes
	localparam logic [2:0] MODE_PUT      = 3'd0;
	localparam logic [2:0] MODE_GET      = 3'd1;
	localparam logic [2:0] MODE_REMOVE   = 3'd2;
	localparam logic [2:0] MODE_CONTAINS = 3'd3;
	localparam logic [2:0] MODE_CLEAR    = 3'd4;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// one result word as seen on the output channel
	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic [4:0]  entry_count;
	} result_t;

endpackage

[rtl/kvt_store.sv]
`timescale 1ns / 1ps

module kvt_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 65
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/kvt_ctrl.sv]
`timescale 1ns / 1ps

module kvt_ctrl #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1),
	localparam int EW = 1 + KEY_WIDTH + VALUE_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          mode,
	input  logic [31:0]         lookup_key,
	input  logic signed [31:0]  data_value,
	output logic                out_valid,
	input  logic                out_stall,
	output kvt_pkg::result_t    result,
	input  logic [31:0]         miss_value,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  logic [EW-1:0]       rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [EW-1:0]       wr_data
);

	typedef enum logic [4:0] {
		S_SWEEP  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	state_t                 state_q, state_d;
	logic [AW-1:0]          idx_q;
	logic [2:0]             mode_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic                   chk_s1;
	logic [AW-1:0]          chk_idx_s1;
	logic                   hit_found_q;
	logic [AW-1:0]          hit_idx_q;
	logic [VALUE_WIDTH-1:0] hit_value_q;
	logic                   free_found_q;
	logic [AW-1:0]          free_idx_q;
	logic [CW-1:0]          count_q;
	logic                   out_valid_q;
	kvt_pkg::result_t       out_q;

	logic                   accept;
	logic                   out_free;
	logic                   finish_go;
	logic                   ent_valid;
	logic [KEY_WIDTH-1:0]   ent_key;
	logic [VALUE_WIDTH-1:0] ent_value;
	logic                   ent_match;

	kvt_pkg::status_t       fin_status;
	logic [31:0]            fin_rv;
	logic [CW-1:0]          fin_count;
	logic                   fin_we;
	logic                   fin_keep;
	logic [AW-1:0]          fin_addr;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign finish_go = (state_q == S_FINISH) && out_free;

	assign out_valid = out_valid_q;
	assign result    = out_q;

	// entry word: {valid, key, value}
	assign ent_valid = rd_data[EW-1];
	assign ent_key   = rd_data[VALUE_WIDTH +: KEY_WIDTH];
	assign ent_value = rd_data[VALUE_WIDTH-1:0];
	assign ent_match = ent_valid && ((mode_q == kvt_pkg::MODE_CONTAINS) ?
		(ent_value == val_q) : (ent_key == key_q));

	assign rd_en   = (state_q == S_SCAN);
	assign rd_addr = idx_q;

	always_comb begin
		fin_status = kvt_pkg::STAT_MISS;
		fin_rv     = miss_value;
		fin_count  = count_q;
		fin_we     = 1'b0;
		fin_keep   = 1'b1;
		fin_addr   = hit_idx_q;
		unique case (mode_q)
			kvt_pkg::MODE_PUT: begin
				if (hit_found_q) begin
					fin_status = kvt_pkg::STAT_DONE;
					fin_we     = 1'b1;
				end else if (free_found_q) begin
					fin_status = kvt_pkg::STAT_DONE;
					fin_we     = 1'b1;
					fin_addr   = free_idx_q;
					fin_count  = count_q + CW'(1);
				end else begin
					fin_status = kvt_pkg::STAT_FULL;
				end
			end
			kvt_pkg::MODE_GET, kvt_pkg::MODE_CONTAINS: begin
				if (hit_found_q) begin
					fin_status = kvt_pkg::STAT_DONE;
					fin_rv     = 32'(hit_value_q);
				end
			end
			kvt_pkg::MODE_REMOVE: begin
				if (hit_found_q) begin
					fin_status = kvt_pkg::STAT_DONE;
					fin_rv     = 32'(hit_value_q);
					fin_we     = 1'b1;
					fin_keep   = 1'b0;
					if (count_q != '0) begin
						fin_count = count_q - CW'(1);
					end
				end
			end
			kvt_pkg::MODE_CLEAR: begin
				fin_status = kvt_pkg::STAT_DONE;
				fin_count  = '0;
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = (state_q == S_SWEEP) || (finish_go && fin_we);
	assign wr_addr = (state_q == S_SWEEP) ? idx_q : fin_addr;
	assign wr_data = (state_q == S_SWEEP) ? '0 : {fin_keep, key_q, val_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (idx_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = (mode_q == kvt_pkg::MODE_CLEAR) ? S_SWEEP : S_IDLE;
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			idx_q        <= '0;
			chk_s1       <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= (state_q == S_SCAN);

			if (state_q == S_SWEEP || state_q == S_SCAN) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);
			end

			if (accept) begin
				hit_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else if (chk_s1) begin
				// first hit and first free slot win
				if (ent_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!ent_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			if (finish_go) begin
				count_q     <= fin_count;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= idx_q;
		if (accept) begin
			mode_q <= mode;
			key_q  <= KEY_WIDTH'(lookup_key);
			val_q  <= VALUE_WIDTH'($unsigned(data_value));
		end
		if (chk_s1 && ent_match && !hit_found_q) begin
			hit_idx_q   <= chk_idx_s1;
			hit_value_q <= ent_value;
		end
		if (chk_s1 && !ent_valid && !free_found_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (finish_go) begin
			out_q.status      <= fin_status;
			out_q.read_value  <= fin_rv;
			out_q.entry_count <= 5'(fin_count);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("read and write in the same cycle");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN) && (idx_q == '0))
		else $error("accepted word did not start a scan at entry zero");

	a_chk_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> $past(state_q == S_SCAN))
		else $error("compare without a preceding read");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside finish");

endmodule

[rtl/key_value_table.sv]
`timescale 1ns / 1ps

// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------
// in       | in_valid/in_stall  | mode, lookup_key, data_value
// out      | out_valid/out_stall| status, read_value, entry_count
// cfg      | cfg_wr_en          | cfg_wr_data (miss value)
//
// A request is accepted in idle, then reads all entries of the single entry
// memory with one read per cycle; a wait state takes the last read data, and
// a finish state writes back and loads the output register. The block then
// returns to idle; in_stall holds off the next word while a request runs.
// Clear adds a sweep that invalidates every entry.
// After reset the same sweep runs; in_stall stays high until it ends.
// A held output word stalls the block in its write-back state; a new word is
// taken while the last result still waits on out_stall.
module key_value_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic [31:0]        lookup_key,
	input  logic signed [31:0] data_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] read_value,
	output logic [4:0]         entry_count,
	input  logic               cfg_wr_en,
	input  logic signed [31:0] cfg_wr_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int EW = 1 + KEY_WIDTH + VALUE_WIDTH;

	logic [31:0]      miss_q;
	kvt_pkg::result_t result;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [EW-1:0]    rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [EW-1:0]    wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= '1;
		end else if (cfg_wr_en) begin
			miss_q <= cfg_wr_data;
		end
	end

	kvt_store #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (EW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	kvt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.lookup_key (lookup_key),
		.data_value (data_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.miss_value (miss_q),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	assign status      = result.status;
	assign read_value  = result.read_value;
	assign entry_count = result.entry_count;

endmodule

[bench/key_value_table_tb.sv]
`timescale 1ns / 1ps

module key_value_table_tb;

	localparam int TBL_DEPTH      = 16;
	localparam int POOL_KEYS      = 24;
	localparam int POOL_VALUES    = 8;
	localparam int PHASE_WORDS    = 400;
	localparam int PHASES         = 5;
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 2 * TBL_DEPTH + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;

	// codes the block decodes as no-ops
	localparam logic [2:0] MODE_FIRST_SPARE = 3'd5;
	localparam logic [2:0] MODE_MID_SPARE   = 3'd6;
	localparam logic [2:0] MODE_LAST_SPARE  = 3'd7;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_pattern_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic [2:0]         mode        = kvt_pkg::MODE_GET;
	logic [31:0]        lookup_key  = '0;
	logic signed [31:0] data_value  = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] read_value;
	logic [4:0]         entry_count;
	logic               cfg_wr_en   = 1'b0;
	logic signed [31:0] cfg_wr_data = '0;

	// shadow of the table as it stands after every accepted word
	logic [31:0] tbl_key [TBL_DEPTH];
	logic [31:0] tbl_val [TBL_DEPTH];
	logic        tbl_used [TBL_DEPTH];
	int          tbl_count;
	logic [31:0] miss_val;

	kvt_pkg::result_t answers_due[$];
	int          mismatches  = 0;
	int          quiet_cycles = 0;

	logic [31:0] key_pool [POOL_KEYS];
	logic [31:0] value_pool [POOL_VALUES];

	bit          tx_gaps     = 1'b1;
	int          burst_left  = 0;
	rx_pattern_t rx_pattern  = RX_LIGHT;
	logic        hold_req    = 1'b0;
	int          hold_left   = 0;
	int          rx_tick     = 0;

	key_value_table #(
		.TABLE_DEPTH(TBL_DEPTH),
		.KEY_WIDTH  (32),
		.VALUE_WIDTH(32)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.lookup_key (lookup_key),
		.data_value (data_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.entry_count(entry_count),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int find_key(input logic [31:0] key);
		int slot;
		int i;
		slot = -1;
		for (i = 0; i < TBL_DEPTH; i++)
			if (slot < 0 && tbl_used[i] && tbl_key[i] == key)
				slot = i;
		return slot;
	endfunction

	// applies one request to the shadow table and returns the word it yields
	function automatic kvt_pkg::result_t table_apply(input logic [2:0] op,
						input logic [31:0] key, input logic [31:0] val);
		kvt_pkg::result_t r;
		int      slot;
		int      i;
		r.status     = kvt_pkg::STAT_MISS;
		r.read_value = miss_val;
		slot         = -1;
		case (op)
		kvt_pkg::MODE_PUT: begin
			slot = find_key(key);
			if (slot >= 0) begin
				tbl_val[slot] = val;
				r.status = kvt_pkg::STAT_DONE;
			end else begin
				for (i = 0; i < TBL_DEPTH; i++)
					if (slot < 0 && !tbl_used[i])
						slot = i;
				if (slot >= 0) begin
					tbl_key[slot]  = key;
					tbl_val[slot]  = val;
					tbl_used[slot] = 1'b1;
					tbl_count++;
					r.status = kvt_pkg::STAT_DONE;
				end else begin
					r.status = kvt_pkg::STAT_FULL;
				end
			end
		end
		kvt_pkg::MODE_GET: begin
			slot = find_key(key);
			if (slot >= 0) begin
				r.read_value = tbl_val[slot];
				r.status = kvt_pkg::STAT_DONE;
			end
		end
		kvt_pkg::MODE_REMOVE: begin
			slot = find_key(key);
			if (slot >= 0) begin
				r.read_value = tbl_val[slot];
				tbl_used[slot] = 1'b0;
				if (tbl_count > 0)
					tbl_count--;
				r.status = kvt_pkg::STAT_DONE;
			end
		end
		kvt_pkg::MODE_CONTAINS: begin
			for (i = 0; i < TBL_DEPTH; i++)
				if (r.status == kvt_pkg::STAT_MISS && tbl_used[i] &&
				    tbl_val[i] == val) begin
					r.read_value = tbl_val[i];
					r.status = kvt_pkg::STAT_DONE;
				end
		end
		kvt_pkg::MODE_CLEAR: begin
			for (i = 0; i < TBL_DEPTH; i++)
				tbl_used[i] = 1'b0;
			tbl_count = 0;
			r.status = kvt_pkg::STAT_DONE;
		end
		default: ;
		endcase
		r.entry_count = tbl_count[4:0];
		return r;
	endfunction

	// offers one word; returns at the edge where it was taken
	task automatic issue_request(input logic [2:0] op, input logic [31:0] key,
				     input logic [31:0] val);
		if (tx_gaps && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = $urandom_range(16, 1);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid   <= 1'b1;
		mode       <= op;
		lookup_key <= key;
		data_value <= val;
		do @(posedge clk); while (in_stall);
		answers_due.push_back(table_apply(op, key, val));
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_miss(input logic [31:0] v);
		drain_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		miss_val    = v;
	endtask

	task automatic reseed_pools();
		int i;
		for (i = 0; i < POOL_KEYS; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		for (i = 4; i < POOL_VALUES; i++)
			value_pool[i] = $urandom;
	endtask

	// keys mostly from a small pool so the table fills and hits repeat
	task automatic random_request();
		logic [2:0]  op;
		logic [31:0] key;
		logic [31:0] val;
		int          pick;
		int          i;
		pick = $urandom_range(99, 0);
		key  = ($urandom_range(7, 0) == 0) ? 32'($urandom) :
			key_pool[$urandom_range(POOL_KEYS - 1, 0)];
		val  = ($urandom_range(1, 0) == 0) ? 32'($urandom) :
			value_pool[$urandom_range(POOL_VALUES - 1, 0)];
		if (pick < 42) begin
			op = kvt_pkg::MODE_PUT;
		end else if (pick < 64) begin
			op = kvt_pkg::MODE_GET;
		end else if (pick < 78) begin
			op = kvt_pkg::MODE_REMOVE;
		end else if (pick < 96) begin
			op = kvt_pkg::MODE_CONTAINS;
			for (i = 0; i < TBL_DEPTH; i++)
				if (tbl_used[i] && $urandom_range(2, 0) == 0)
					val = tbl_val[i];
		end else if (pick < 97) begin
			op = kvt_pkg::MODE_CLEAR;
		end else begin
			op = 3'($urandom_range(MODE_LAST_SPARE, MODE_FIRST_SPARE));
		end
		issue_request(op, key, val);
	endtask

	task automatic test_empty_table();
		issue_request(kvt_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_CONTAINS, 32'h0000_0000, 32'h0000_0000);
		issue_request(MODE_FIRST_SPARE, 32'h1234_5678, 32'h0000_0001);
		issue_request(MODE_MID_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_request(MODE_LAST_SPARE, 32'h0000_0000, 32'h8000_0000);
	endtask

	task automatic test_basic_ops();
		write_miss(32'h8000_0000);
		issue_request(kvt_pkg::MODE_PUT, 32'h0000_0000, 32'h8000_0000);
		issue_request(kvt_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		issue_request(kvt_pkg::MODE_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		issue_request(kvt_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_CONTAINS, 32'h0000_0000, 32'h7FFF_FFFF);
		issue_request(kvt_pkg::MODE_CONTAINS, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_GET, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_PUT, 32'h5555_AAAA, 32'h0000_0001);
		issue_request(kvt_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_GET, 32'h5555_AAAA, 32'h0000_0000);
	endtask

	task automatic test_full_table();
		int i;
		write_miss(32'h7FFF_FFFF);
		for (i = 0; i < TBL_DEPTH; i++)
			issue_request(kvt_pkg::MODE_PUT, 32'h1000_0000 * i + i, 32'(i * 3 - 20));
		issue_request(kvt_pkg::MODE_PUT, 32'hDEAD_0001, 32'h0000_0042);
		issue_request(kvt_pkg::MODE_PUT, 32'h1000_0000 * 5 + 5, 32'h0000_0042);
		issue_request(kvt_pkg::MODE_CONTAINS, 32'h0000_0000, 32'h0000_0042);
		issue_request(kvt_pkg::MODE_REMOVE, 32'h1000_0000 * 9 + 9, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_PUT, 32'hDEAD_0001, 32'h0000_0043);
		issue_request(kvt_pkg::MODE_GET, 32'hDEAD_0001, 32'h0000_0000);
		issue_request(kvt_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
	endtask

	// output held off long enough that the input side backs up
	task automatic test_backpressure();
		int i;
		drain_block();
		reseed_pools();
		tx_gaps    = 1'b0;
		rx_pattern <= RX_OPEN;
		hold_req   <= 1'b1;
		@(posedge clk);
		hold_req   <= 1'b0;
		for (i = 0; i < 30; i++)
			random_request();
		drain_block();
	endtask

	task automatic test_random_phases();
		int phase;
		int i;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: write_miss(32'h0000_0000);
			2: write_miss(32'hFFFF_FFFF);
			default: write_miss($urandom);
			endcase
			reseed_pools();
			tx_gaps    = (phase != 0);
			rx_pattern <= rx_pattern_t'(phase % 4);
			for (i = 0; i < PHASE_WORDS; i++)
				random_request();
		end
	endtask

	always @(posedge clk) begin
		if (hold_req && hold_left == 0)
			hold_left = HOLD_CYCLES;
		rx_tick++;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_pattern)
			RX_OPEN:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(3, 0) != 0);
			default:  out_stall <= ((rx_tick % 11) < 4);
			endcase
		end
	end

	always @(posedge clk) begin
		kvt_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected word: status %0d value %h count %0d",
						 status, read_value, entry_count);
			end else begin
				want = answers_due.pop_front();
				if (status !== want.status || read_value !== want.read_value ||
				    entry_count !== want.entry_count) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: status %0d/%0d value %h/%h count %0d/%0d (exp/act)",
							 want.status, status, want.read_value, read_value,
							 want.entry_count, entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("key_value_table verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		for (i = 0; i < TBL_DEPTH; i++) begin
			tbl_key[i]  = '0;
			tbl_val[i]  = '0;
			tbl_used[i] = 1'b0;
		end
		tbl_count = 0;
		miss_val  = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_basic_ops();
		test_full_table();
		test_backpressure();
		test_random_phases();
		drain_block();

		if (mismatches == 0)
			$display("key_value_table verification clean");
		else
			$display("key_value_table verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/kvt_pkg.sv
rtl/kvt_store.sv
rtl/kvt_ctrl.sv
rtl/key_value_table.sv
bench/key_value_table_tb.sv
